// ===== rtl/cbfe_pkg.sv =====
// Shared constants, payload types and arithmetic helpers for the camera basis block.
`default_nettype none

package cbfe_pkg;

  localparam int unsigned ANGLE_BITS  = 16;
  localparam int unsigned FRAC_BITS   = 14;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned QB          = 30;
  localparam int unsigned TW          = 31;
  localparam int unsigned SW          = 32;
  localparam int unsigned XW          = 72;
  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [TW-1:0] IONE      = TW'(1) << QB;
  localparam int unsigned N_STEPS     = 7;
  localparam int unsigned N_SIN       = 6;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned RW          = 38;
  localparam int unsigned RLO         = 19;
  localparam int unsigned TRIG_LAT    = 2 + 3 * N_STEPS + 2;
  localparam int unsigned POST_LAT    = 5;
  localparam int unsigned PIPE_DEPTH  = TRIG_LAT + POST_LAT;
  localparam logic signed [XW-1:0] LIM = XW'(1) <<< FRAC_BITS;

  typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quadrant_e;

  typedef struct packed {
    logic [FIELD_W-1:0] yaw_angle;
    logic [FIELD_W-1:0] pitch_angle;
    logic [FIELD_W-1:0] roll_angle;
  } in_beat_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] front_x;
    logic signed [FIELD_W-1:0] front_y;
    logic signed [FIELD_W-1:0] front_z;
    logic signed [FIELD_W-1:0] right_x;
    logic signed [FIELD_W-1:0] right_y;
    logic signed [FIELD_W-1:0] right_z;
    logic signed [FIELD_W-1:0] up_x;
    logic signed [FIELD_W-1:0] up_y;
    logic signed [FIELD_W-1:0] up_z;
    logic                      degenerate;
  } out_beat_t;

  function automatic int unsigned sin_div(int unsigned i);
    case (i)
      0: return 156;
      1: return 110;
      2: return 72;
      3: return 42;
      4: return 20;
      default: return 6;
    endcase
  endfunction

  function automatic int unsigned cos_div(int unsigned i);
    case (i)
      0: return 182;
      1: return 132;
      2: return 90;
      3: return 56;
      4: return 30;
      5: return 12;
      default: return 2;
    endcase
  endfunction

  // Q30 product with rounding, on unsigned values.
  function automatic logic [TW-1:0] umulq(logic [TW-1:0] a, logic [TW-1:0] b);
    logic [2*TW-1:0] p;
    p = (2*TW)'(a) * (2*TW)'(b) + ((2*TW)'(1) << (QB - 1));
    return TW'(p >> QB);
  endfunction

  // Arithmetic shift right with rounding half away from zero.
  function automatic logic signed [XW-1:0] rshr(logic signed [XW-1:0] v, int unsigned sh);
    logic [XW-1:0] m;
    logic [XW-1:0] r;
    m = v[XW-1] ? XW'(-v) : XW'(v);
    r = (m + (XW'(1) << (sh - 1))) >> sh;
    return v[XW-1] ? -$signed(r) : $signed(r);
  endfunction

  // Clamp to plus or minus one and keep the field width.
  function automatic logic [FIELD_W-1:0] emit(logic signed [XW-1:0] v);
    logic signed [XW-1:0] c;
    c = v;
    if (c > LIM) c = LIM;
    if (c < -LIM) c = -LIM;
    return FIELD_W'(c);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cbfe_in_if.sv =====
// Input channel: valid, ready and one pose beat.
`default_nettype none

interface cbfe_in_if;
  import cbfe_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbfe_out_if.sv =====
// Output channel: valid, ready and one basis beat.
`default_nettype none

interface cbfe_out_if;
  import cbfe_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/cbfe_trig.sv =====
// Pipelined sine and cosine of a binary angle in Q30, Horner series with constant dividers.
`default_nettype none

module cbfe_trig import cbfe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FIELD_W-1:0]   angle_i,
  output logic signed [SW-1:0] sin_o,
  output logic signed [SW-1:0] cos_o
);

  localparam int unsigned TB = ANGLE_BITS - 2;
  localparam int unsigned PW = TB + 34;
  localparam logic [TB-1:0] EIGHTH = TB'(1) << (TB - 1);

  logic [ANGLE_BITS-1:0] ang;
  logic [1:0]            quad_d;
  logic [TB-1:0]         t_d;
  logic [TB-1:0]         x_d;
  logic                  swap_d;
  logic [PW-1:0]         xprod;

  logic [TW-1:0] xr_a_q;
  logic [1:0]    quad_a_q;
  logic          swap_a_q;

  logic [TW-1:0] x2_k   [N_STEPS+1];
  logic [TW-1:0] xr_k   [N_STEPS+1];
  logic [1:0]    quad_k [N_STEPS+1];
  logic          swap_k [N_STEPS+1];
  logic [TW-1:0] ts_k   [N_STEPS+1][2];

  logic [TW-1:0] x2_b_q;
  logic [TW-1:0] xr_b_q;
  logic [1:0]    quad_b_q;
  logic          swap_b_q;

  logic [TW-1:0] sv_q;
  logic [TW-1:0] cv_q;
  logic [1:0]    quad_f_q;
  logic          swap_f_q;
  logic signed [SW-1:0] s_loc;
  logic signed [SW-1:0] c_loc;
  logic signed [SW-1:0] sin_q;
  logic signed [SW-1:0] cos_q;

  // Fold the angle into the first eighth of a turn.
  always_comb begin
    ang    = ANGLE_BITS'(angle_i);
    quad_d = ang[ANGLE_BITS-1 -: 2];
    t_d    = ang[TB-1:0];
    swap_d = t_d > EIGHTH;
    x_d    = swap_d ? TB'(((TB + 1)'(1) << TB) - (TB + 1)'(t_d)) : t_d;
    xprod  = PW'(x_d) * PW'(TWO_PI_Q30) + (PW'(1) << (ANGLE_BITS - 1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xr_a_q   <= TW'(xprod >> ANGLE_BITS);
      quad_a_q <= quad_d;
      swap_a_q <= swap_d;
      x2_b_q   <= umulq(xr_a_q, xr_a_q);
      xr_b_q   <= xr_a_q;
      quad_b_q <= quad_a_q;
      swap_b_q <= swap_a_q;
    end
  end

  assign x2_k[0]    = x2_b_q;
  assign xr_k[0]    = xr_b_q;
  assign quad_k[0]  = quad_b_q;
  assign swap_k[0]  = swap_b_q;
  assign ts_k[0][0] = IONE;
  assign ts_k[0][1] = IONE;

  // Each Horner step takes three stages: product, reciprocal multiply, subtract.
  for (genvar i = 0; i < N_STEPS; i++) begin : g_step
    logic [TW-1:0] x2_c_q   [3];
    logic [TW-1:0] xr_c_q   [3];
    logic [1:0]    quad_c_q [3];
    logic          swap_c_q [3];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x2_c_q[0]   <= x2_k[i];
        xr_c_q[0]   <= xr_k[i];
        quad_c_q[0] <= quad_k[i];
        swap_c_q[0] <= swap_k[i];
        for (int k = 1; k < 3; k++) begin
          x2_c_q[k]   <= x2_c_q[k-1];
          xr_c_q[k]   <= xr_c_q[k-1];
          quad_c_q[k] <= quad_c_q[k-1];
          swap_c_q[k] <= swap_c_q[k-1];
        end
      end
    end

    assign x2_k[i+1]   = x2_c_q[2];
    assign xr_k[i+1]   = xr_c_q[2];
    assign quad_k[i+1] = quad_c_q[2];
    assign swap_k[i+1] = swap_c_q[2];

    for (genvar j = 0; j < 2; j++) begin : g_lane
      if (j == 1 || i < N_SIN) begin : g_div
        localparam int unsigned D = (j == 0) ? sin_div(i) : cos_div(i);
        localparam logic [RW-1:0] RECIP =
          RW'(((64'd1 << RECIP_SHIFT) + 64'(D) - 64'd1) / 64'(D));
        logic [2*TW-1:0]   m_q;
        logic [TW-1:0]     p;
        logic [TW+RLO-1:0] pl_q;
        logic [TW+RLO-1:0] ph_q;
        logic [TW+RW:0]    qsum;
        logic [TW-1:0]     ts_q;

        // The reciprocal is rounded up, which gives the exact floor for these operands.
        always_comb begin
          p    = TW'((m_q + ((2*TW)'(1) << (QB - 1))) >> QB);
          qsum = ((TW + RW + 1)'(ph_q) << RLO) + (TW + RW + 1)'(pl_q);
        end

        always_ff @(posedge clk_i) begin
          if (en_i) begin
            m_q  <= (2*TW)'(x2_k[i]) * (2*TW)'(ts_k[i][j]);
            pl_q <= (TW+RLO)'(p) * (TW+RLO)'(RECIP[RLO-1:0]);
            ph_q <= (TW+RLO)'(p) * (TW+RLO)'(RECIP[RW-1:RLO]);
            ts_q <= IONE - TW'(qsum >> RECIP_SHIFT);
          end
        end
        assign ts_k[i+1][j] = ts_q;
      end else begin : g_pass
        logic [TW-1:0] h_q [3];
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            h_q[0] <= ts_k[i][j];
            h_q[1] <= h_q[0];
            h_q[2] <= h_q[1];
          end
        end
        assign ts_k[i+1][j] = h_q[2];
      end
    end
  end

  always_comb begin
    s_loc = swap_f_q ? SW'(cv_q) : SW'(sv_q);
    c_loc = swap_f_q ? SW'(sv_q) : SW'(cv_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv_q     <= umulq(xr_k[N_STEPS], ts_k[N_STEPS][0]);
      cv_q     <= ts_k[N_STEPS][1];
      quad_f_q <= quad_k[N_STEPS];
      swap_f_q <= swap_k[N_STEPS];
      case (quadrant_e'(quad_f_q))
        QUAD_I: begin
          sin_q <= s_loc;
          cos_q <= c_loc;
        end
        QUAD_II: begin
          sin_q <= c_loc;
          cos_q <= -s_loc;
        end
        QUAD_III: begin
          sin_q <= -s_loc;
          cos_q <= -c_loc;
        end
        default: begin
          sin_q <= -c_loc;
          cos_q <= s_loc;
        end
      endcase
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

`default_nettype wire

// ===== rtl/camera_basis_from_euler_angles.sv =====
// Top level: front, right and rolled up vectors from yaw, pitch and roll.
//
//   channel  direction  beat contents
//   in_i     sink       yaw_angle, pitch_angle, roll_angle (16-bit binary angles)
//   out_o    source     front, right, up vectors in Q2.14, degenerate flag
//
// One beat enters per cycle while the pipeline is not held by a waiting output beat.
// Each trig unit takes 25 stages: two to fold the angle and square it, seven
// Horner steps of three stages each, and two for the last product and the
// quadrant; five more stages form the products, rounding and clamping.
// The whole pipeline advances together and holds when the output beat waits.
// Reset clears only the valid bits; data registers are left as they are.
`default_nettype none

module camera_basis_from_euler_angles import cbfe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  cbfe_in_if.sink    in_i,
  cbfe_out_if.source out_o
);

  logic en;
  logic vld_q [PIPE_DEPTH];

  logic signed [SW-1:0] ys, yc, ps, pc, rs, rc;

  // Stage T1
  logic signed [2*SW-1:0] p_sp_q, p_cp_q, p_ss_q, p_cs_q;
  logic signed [SW-1:0]   ys1_q, yc1_q, ps1_q, pc1_q, rs1_q, rc1_q;
  // Stage T2
  logic signed [SW+1:0]   fx2_q, fz2_q, ux2_q, uz2_q;
  logic signed [SW-1:0]   fy2_q, rx2_q, rz2_q, uy2_q, rs2_q, rc2_q;
  logic                   dg2_q;
  logic signed [SW+1:0]   a_rnd, b_rnd;
  logic                   neg1;
  // Stage T3
  logic signed [2*SW+1:0] uxc_q, uzc_q, uyc_q;
  logic signed [2*SW-1:0] rxs_q, rzs_q;
  logic signed [SW+1:0]   fx3_q, fz3_q;
  logic signed [SW-1:0]   fy3_q, rx3_q, rz3_q;
  logic                   dg3_q;
  // Stage T4
  logic signed [2*SW+2:0] ox4_q, oz4_q;
  logic signed [2*SW+1:0] oy4_q;
  logic signed [SW+1:0]   fx4_q, fz4_q;
  logic signed [SW-1:0]   fy4_q, rx4_q, rz4_q;
  logic                   dg4_q;
  // Stage T5, the output register
  out_beat_t out_q;

  localparam int unsigned SH = QB - FRAC_BITS;

  assign en       = !vld_q[PIPE_DEPTH-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_DEPTH; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_i.valid;
      for (int k = 1; k < PIPE_DEPTH; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  cbfe_trig u_trig_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_i.payload.yaw_angle),
    .sin_o   (ys),
    .cos_o   (yc)
  );

  cbfe_trig u_trig_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_i.payload.pitch_angle),
    .sin_o   (ps),
    .cos_o   (pc)
  );

  cbfe_trig u_trig_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_i.payload.roll_angle),
    .sin_o   (rs),
    .cos_o   (rc)
  );

  always_comb begin
    a_rnd = (SW+2)'(rshr(XW'(p_ss_q), QB));
    b_rnd = (SW+2)'(rshr(XW'(p_cs_q), QB));
    neg1  = pc1_q < 0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // T1: yaw by pitch products.
      p_sp_q <= ys * pc;
      p_cp_q <= yc * pc;
      p_ss_q <= ys * ps;
      p_cs_q <= yc * ps;
      ys1_q  <= ys;
      yc1_q  <= yc;
      ps1_q  <= ps;
      pc1_q  <= pc;
      rs1_q  <= rs;
      rc1_q  <= rc;

      // T2: round back to Q30 and fold in the sign of cos pitch.
      fx2_q <= (SW+2)'(rshr(XW'(p_sp_q), QB));
      fz2_q <= (SW+2)'(rshr(XW'(p_cp_q), QB));
      fy2_q <= ps1_q;
      rx2_q <= neg1 ? yc1_q : -yc1_q;
      rz2_q <= neg1 ? -ys1_q : ys1_q;
      ux2_q <= neg1 ? a_rnd : -a_rnd;
      uz2_q <= neg1 ? b_rnd : -b_rnd;
      uy2_q <= neg1 ? -pc1_q : pc1_q;
      dg2_q <= pc1_q == '0;
      rs2_q <= rs1_q;
      rc2_q <= rc1_q;

      // T3: roll products in Q60.
      uxc_q <= (2*SW+2)'(ux2_q) * (2*SW+2)'(rc2_q);
      uzc_q <= (2*SW+2)'(uz2_q) * (2*SW+2)'(rc2_q);
      uyc_q <= (2*SW+2)'(uy2_q) * (2*SW+2)'(rc2_q);
      rxs_q <= rx2_q * rs2_q;
      rzs_q <= rz2_q * rs2_q;
      fx3_q <= fx2_q;
      fz3_q <= fz2_q;
      fy3_q <= fy2_q;
      rx3_q <= rx2_q;
      rz3_q <= rz2_q;
      dg3_q <= dg2_q;

      // T4: sums for the rotated up vector.
      ox4_q <= (2*SW+3)'(uxc_q) - (2*SW+3)'(rxs_q);
      oz4_q <= (2*SW+3)'(uzc_q) - (2*SW+3)'(rzs_q);
      oy4_q <= uyc_q;
      fx4_q <= fx3_q;
      fz4_q <= fz3_q;
      fy4_q <= fy3_q;
      rx4_q <= rx3_q;
      rz4_q <= rz3_q;
      dg4_q <= dg3_q;

      // T5: final rounding and clamping.
      out_q.front_x    <= $signed(emit(rshr(XW'(fx4_q), SH)));
      out_q.front_y    <= $signed(emit(rshr(XW'(fy4_q), SH)));
      out_q.front_z    <= $signed(emit(rshr(XW'(fz4_q), SH)));
      out_q.right_y    <= '0;
      out_q.degenerate <= dg4_q;
      if (dg4_q) begin
        out_q.right_x <= '0;
        out_q.right_z <= '0;
        out_q.up_x    <= '0;
        out_q.up_y    <= '0;
        out_q.up_z    <= '0;
      end else begin
        out_q.right_x <= $signed(emit(rshr(XW'(rx4_q), SH)));
        out_q.right_z <= $signed(emit(rshr(XW'(rz4_q), SH)));
        out_q.up_x    <= $signed(emit(rshr(XW'(ox4_q), 2 * QB - FRAC_BITS)));
        out_q.up_y    <= $signed(emit(rshr(XW'(oy4_q), 2 * QB - FRAC_BITS)));
        out_q.up_z    <= $signed(emit(rshr(XW'(oz4_q), 2 * QB - FRAC_BITS)));
      end
    end
  end

  assign out_o.valid   = vld_q[PIPE_DEPTH-1];
  assign out_o.payload = out_q;

  // A waiting output beat must hold the whole pipeline, input included.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output beat waits");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.payload.degenerate) |->
      (out_o.payload.right_x == 0 && out_o.payload.right_z == 0 &&
       out_o.payload.up_x == 0 && out_o.payload.up_y == 0 &&
       out_o.payload.up_z == 0 && out_o.payload.front_x == 0 &&
       out_o.payload.front_z == 0))
    else $error("degenerate beat carries nonzero right, up or horizontal front");

  a_right_y_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.payload.right_y == 0)
    else $error("right_y is not zero");

  a_front_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.payload.front_y <= 16'sd16384 &&
                     out_o.payload.front_y >= -16'sd16384))
    else $error("front_y outside unit range");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the camera basis block: random poses, random idling, field-by-field compare.
`default_nettype none

module tb;
  import cbfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  cbfe_in_if  in_ch();
  cbfe_out_if out_ch();

  camera_basis_from_euler_angles dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  typedef struct {
    longint s;
    longint c;
  } sincos_t;

  in_beat_t  pose_q[$];
  out_beat_t basis_q[$];
  int        err_cnt = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;
  bit        stim_done = 1'b0;

  // Truncating divisors of the Horner steps for sin and cos.
  longint unsigned sin_dv[6] = '{156, 110, 72, 42, 20, 6};
  longint unsigned cos_dv[7] = '{182, 132, 90, 56, 30, 12, 2};

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint round_shift(longint v, int sh);
    longint unsigned m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Products up to Q60 fit in 64 bits since all inputs are at most 2^30.
  function automatic longint round_shift_wide(longint v, int sh);
    return round_shift(v, sh);
  endfunction

  function automatic sincos_t angle_trig(logic [15:0] a);
    longint unsigned t, x, xr, x2, ts, tc, sv, cv;
    longint s, c;
    sincos_t r;
    t = a[13:0];
    x = (t <= 8192) ? t : 16384 - t;
    xr = (x * 64'd6746518852 + 64'd32768) >> 16;
    x2 = q30_mul(xr, xr);
    ts = 64'd1 << 30;
    for (int i = 0; i < 6; i++) ts = (64'd1 << 30) - q30_mul(x2, ts) / sin_dv[i];
    sv = q30_mul(xr, ts);
    tc = 64'd1 << 30;
    for (int i = 0; i < 7; i++) tc = (64'd1 << 30) - q30_mul(x2, tc) / cos_dv[i];
    cv = tc;
    if (t <= 8192) begin
      s = sv; c = cv;
    end else begin
      s = cv; c = sv;
    end
    case (quadrant_e'(a[15:14]))
      QUAD_I:   begin r.s = s;  r.c = c;  end
      QUAD_II:  begin r.s = c;  r.c = -s; end
      QUAD_III: begin r.s = -s; r.c = -c; end
      default:  begin r.s = -c; r.c = s;  end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] clamp_field(longint v);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  function automatic out_beat_t camera_basis(in_beat_t p);
    sincos_t yw, pt, rl;
    longint fx, fz, rx, rz, ux, uy, uz, ox, oy, oz, sg;
    out_beat_t o;
    yw = angle_trig(p.yaw_angle);
    pt = angle_trig(p.pitch_angle);
    rl = angle_trig(p.roll_angle);
    fx = round_shift(yw.s * pt.c, 30);
    fz = round_shift(yw.c * pt.c, 30);
    rx = 0; rz = 0; ox = 0; oy = 0; oz = 0;
    o.degenerate = (pt.c == 0);
    if (!o.degenerate) begin
      sg = pt.c > 0 ? 1 : -1;
      rx = -sg * yw.c;
      rz = sg * yw.s;
      ux = -sg * round_shift(yw.s * pt.s, 30);
      uy = pt.c < 0 ? -pt.c : pt.c;
      uz = -sg * round_shift(yw.c * pt.s, 30);
      ox = round_shift_wide(ux * rl.c - rx * rl.s, 46);
      oy = round_shift_wide(uy * rl.c, 46);
      oz = round_shift_wide(uz * rl.c - rz * rl.s, 46);
      rx = round_shift(rx, 16);
      rz = round_shift(rz, 16);
    end
    o.front_x = clamp_field(round_shift(fx, 16));
    o.front_y = clamp_field(round_shift(pt.s, 16));
    o.front_z = clamp_field(round_shift(fz, 16));
    o.right_x = clamp_field(rx);
    o.right_y = '0;
    o.right_z = clamp_field(rz);
    o.up_x = clamp_field(ox);
    o.up_y = clamp_field(oy);
    o.up_z = clamp_field(oz);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Driver: one pose per accepted beat, random gaps when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.payload <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pose_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        in_ch.payload <= pose_q[0];
        in_ch.valid <= 1'b1;
        basis_q.push_back(camera_basis(pose_q[0]));
        void'(pose_q.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor and sink stall.
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (basis_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = basis_q.pop_front();
          if (out_ch.payload.front_x !== want.front_x)
            report_mismatch("front_x", out_ch.payload.front_x, want.front_x);
          if (out_ch.payload.front_y !== want.front_y)
            report_mismatch("front_y", out_ch.payload.front_y, want.front_y);
          if (out_ch.payload.front_z !== want.front_z)
            report_mismatch("front_z", out_ch.payload.front_z, want.front_z);
          if (out_ch.payload.right_x !== want.right_x)
            report_mismatch("right_x", out_ch.payload.right_x, want.right_x);
          if (out_ch.payload.right_y !== want.right_y)
            report_mismatch("right_y", out_ch.payload.right_y, want.right_y);
          if (out_ch.payload.right_z !== want.right_z)
            report_mismatch("right_z", out_ch.payload.right_z, want.right_z);
          if (out_ch.payload.up_x !== want.up_x)
            report_mismatch("up_x", out_ch.payload.up_x, want.up_x);
          if (out_ch.payload.up_y !== want.up_y)
            report_mismatch("up_y", out_ch.payload.up_y, want.up_y);
          if (out_ch.payload.up_z !== want.up_z)
            report_mismatch("up_z", out_ch.payload.up_z, want.up_z);
          if (out_ch.payload.degenerate !== want.degenerate)
            report_mismatch("degenerate", out_ch.payload.degenerate, want.degenerate);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  function automatic in_beat_t mk_pose(logic [15:0] y, logic [15:0] p, logic [15:0] r);
    in_beat_t b;
    b.yaw_angle = y;
    b.pitch_angle = p;
    b.roll_angle = r;
    return b;
  endfunction

  task automatic run_phase(int idle, int stall, int n);
    src_idle_pct = idle;
    snk_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        // Poses near the vertical and the octant boundaries.
        0: pose_q.push_back(mk_pose(16'($urandom), 16'h4000 + 16'($urandom_range(4)) - 16'd2
                                    + 16'($urandom_range(1) * 16'h8000), 16'($urandom)));
        1: pose_q.push_back(mk_pose(16'($urandom_range(7)) * 16'h2000, 16'($urandom),
                                    16'($urandom_range(7)) * 16'h2000));
        default: pose_q.push_back(mk_pose(16'($urandom), 16'($urandom), 16'($urandom)));
      endcase
    end
    while (pose_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: extremes, every quadrant, octant edges, vertical front both ways.
    pose_q.push_back(mk_pose(16'h0000, 16'h0000, 16'h0000));
    pose_q.push_back(mk_pose(16'hFFFF, 16'hFFFF, 16'hFFFF));
    pose_q.push_back(mk_pose(16'h4000, 16'h4000, 16'h0000));
    pose_q.push_back(mk_pose(16'h1234, 16'hC000, 16'h4000));
    pose_q.push_back(mk_pose(16'h2000, 16'h2000, 16'h2000));
    pose_q.push_back(mk_pose(16'h2001, 16'h1FFF, 16'h6000));
    pose_q.push_back(mk_pose(16'h8000, 16'h8000, 16'h8000));
    pose_q.push_back(mk_pose(16'hC000, 16'h3FFF, 16'hA000));
    pose_q.push_back(mk_pose(16'h6000, 16'h4001, 16'hE000));
    pose_q.push_back(mk_pose(16'hA000, 16'hBFFF, 16'hC000));
    pose_q.push_back(mk_pose(16'hE000, 16'hC001, 16'h3FFF));
    pose_q.push_back(mk_pose(16'h5555, 16'hAAAA, 16'h5555));
    pose_q.push_back(mk_pose(16'hAAAA, 16'h5555, 16'hAAAA));
    pose_q.push_back(mk_pose(16'h0001, 16'h7FFF, 16'h8001));
    run_phase(0, 0, 125);
    run_phase(48, 0, 125);
    run_phase(0, 48, 125);
    run_phase(24, 24, 125);
    while (basis_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
